// ===== design/kmsd_pkg.sv =====
`default_nettype none

package kmsd_pkg;

  localparam int PIN_W      = 8;   // pin_sample / key_levels width
  localparam int SEL_W      = 3;   // select line count
  localparam int SCAN_IDX_W = 2;   // scanned_bank width
  localparam int CFG_IDX_W  = 2;
  localparam int MASK_REGS  = 3;
  localparam int MAX_BANK_W = 3;   // enough for up to 8 banks

  typedef logic [PIN_W-1:0]     pins_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_INVERT_MASK_BANK0 = 2'd0;
  localparam cfg_idx_t REG_INVERT_MASK_BANK1 = 2'd1;
  localparam cfg_idx_t REG_INVERT_MASK_BANK2 = 2'd2;

  localparam pins_t PENDING_RESET = 8'hFF;
  localparam pins_t STABLE_RESET  = 8'h00;

  // active-low one-hot drive; banks without a select line leave all high
  function automatic logic [SEL_W-1:0] select_for(input logic [MAX_BANK_W-1:0] bank);
    logic [SEL_W-1:0] low;
    low = '0;
    if (bank < MAX_BANK_W'(SEL_W)) begin
      low[bank[1:0]] = 1'b1;
    end
    return ~low;
  endfunction

endpackage

`default_nettype wire

// ===== design/key_matrix_scan_debounce.sv =====
// Each accepted pin sample updates the registered results and raises out_valid.
// Throughput: one sample per cycle unless held by out_stall; the debounce update is
//   two bits of logic per key between the input handshake and the result register.
// Reset (rst, synchronous): pending bits all ones, stable bits and masks zero, bank 0,
//   scanner not started; the first sample after reset only selects bank 0.
`default_nettype none

module key_matrix_scan_debounce #(
  parameter int BANK_COUNT    = 3,
  parameter int KEYS_PER_BANK = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire kmsd_pkg::pins_t                 pin_sample,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [kmsd_pkg::SEL_W-1:0]      select_lines,
  output      logic                            scan_valid,
  output      logic [kmsd_pkg::SCAN_IDX_W-1:0] scanned_bank,
  output      kmsd_pkg::pins_t                 key_levels,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire kmsd_pkg::cfg_idx_t              cfg_index,
  input  wire kmsd_pkg::pins_t                 cfg_data
);
  import kmsd_pkg::*;

  localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam pins_t KEY_MASK = pins_t'((9'd1 << KEYS_PER_BANK) - 9'd1);

  typedef logic [BANK_W-1:0] bank_t;

  pins_t invert_mask [MASK_REGS];
  pins_t pending_bits [BANK_COUNT];
  pins_t stable_bits  [BANK_COUNT];
  bank_t current_bank;
  logic  scan_started;

  logic  in_xfer;
  bank_t bank_eff;
  bank_t bank_next;
  pins_t sample;
  pins_t agree;
  pins_t pending_next;
  pins_t stable_next;
  pins_t mask_sel;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_xfer   = in_valid && !in_stall;

  always_comb begin
    bank_eff = (32'(current_bank) < BANK_COUNT) ? current_bank : '0;
    bank_next = ((32'(bank_eff) + 1) >= BANK_COUNT) ? '0 : bank_t'(32'(bank_eff) + 1);
    sample = pin_sample & KEY_MASK;
    // stable follows the sample only where it matches the previous sample
    agree = ~(sample ^ pending_bits[bank_eff]) & KEY_MASK;
    stable_next = (stable_bits[bank_eff] & ~agree) | (sample & agree);
    pending_next = (pending_bits[bank_eff] & ~KEY_MASK) | sample;
    mask_sel = (MAX_BANK_W'(bank_eff) < MAX_BANK_W'(MASK_REGS))
               ? invert_mask[CFG_IDX_W'(bank_eff)] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MASK_REGS; i++) begin
        invert_mask[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INVERT_MASK_BANK0: invert_mask[0] <= cfg_data;
        REG_INVERT_MASK_BANK1: invert_mask[1] <= cfg_data;
        REG_INVERT_MASK_BANK2: invert_mask[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BANK_COUNT; b++) begin
        pending_bits[b] <= PENDING_RESET;
        stable_bits[b]  <= STABLE_RESET;
      end
      current_bank <= '0;
      scan_started <= 1'b0;
    end else if (in_xfer) begin
      if (scan_started) begin
        pending_bits[bank_eff] <= pending_next;
        stable_bits[bank_eff]  <= stable_next;
        current_bank           <= bank_next;
      end else begin
        current_bank <= '0;
        scan_started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (scan_started) begin
        select_lines <= select_for(MAX_BANK_W'(bank_next));
        scan_valid   <= 1'b1;
        scanned_bank <= SCAN_IDX_W'(bank_eff);
        key_levels   <= (stable_next ^ mask_sel) & KEY_MASK;
      end else begin
        select_lines <= select_for('0);
        scan_valid   <= 1'b0;
        scanned_bank <= '0;
        key_levels   <= '0;
      end
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  a_first_tick: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !scan_started) |=> (out_valid && !scan_valid && key_levels == '0))
    else $error("first sample after reset produced a debounced result");

  a_started_scans: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && scan_started) |=> (out_valid && scan_valid))
    else $error("sample after start did not produce a scan result");

  a_select_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones(~select_lines) <= 1))
    else $error("more than one bank selected");

endmodule

`default_nettype wire
